@@ hw/rtl/range_letter_parity_query_assert.svh @@
// Assertion macros shared by the range letter parity query RTL.
// Depends on nothing; included inside module bodies.
`ifndef RANGE_LETTER_PARITY_QUERY_ASSERT_SVH
`define RANGE_LETTER_PARITY_QUERY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpq assertion failed");

`endif

@@ hw/rtl/rlpq_pkg.sv @@
// Shared types, constants and helpers for the range letter parity query block.
// Depends on nothing.
package rlpq_pkg;

    localparam int unsigned LETTERS  = 26;
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned POS_W    = 13;
    localparam int unsigned CNT_W    = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [LETTERS-1:0] t_vec;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_we;    // load beat accepted
        logic query_cap;  // query beat accepted: check range, read store
        logic out_load;   // write result register
    } t_dp_cmd;

    function automatic t_cnt popcount_vec(input t_vec v);
        t_cnt n;
        n = '0;
        for (int i = 0; i < LETTERS; i++) begin
            n = n + t_cnt'(v[i]);
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/rlpq_ctrl.sv @@
// Controller FSM for the range letter parity query block.
// Depends on rlpq_pkg and range_letter_parity_query_assert.svh.
module rlpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_opcode,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output rlpq_pkg::t_dp_cmd o_cmd
);
    import rlpq_pkg::*;
    `include "range_letter_parity_query_assert.svh"

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_opcode == OP_QUERY) begin
                        cmd.query_cap = 1'b1;
                        n_state       = ST_CALC;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                // wait while the previous result is still unclaimed
                if (!r_out_valid || i_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `RLPQ_ASSERT_NEXT(a_query_to_calc, i_clk, i_rst_n, cmd.query_cap, r_state == ST_CALC)
    `RLPQ_ASSERT_NEXT(a_load_stays_idle, i_clk, i_rst_n, cmd.load_we, r_state == ST_IDLE)
    `RLPQ_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, cmd.out_load, r_out_valid)
    `RLPQ_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_ready, !cmd.out_load)

endmodule

@@ hw/rtl/rlpq_dp.sv @@
// Datapath: prefix parity store, running parity, length, range check, popcount.
// Depends on rlpq_pkg.
module rlpq_dp #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rlpq_pkg::t_dp_cmd               i_cmd,
    input  logic [rlpq_pkg::LETTER_W-1:0]   i_letter,
    input  logic [rlpq_pkg::POS_W-1:0]      i_range_start,
    input  logic [rlpq_pkg::POS_W-1:0]      i_range_end,
    output logic [rlpq_pkg::CNT_W-1:0]      o_odd_letters,
    output logic [rlpq_pkg::CNT_W-1:0]      o_even_letters,
    output logic                            o_range_error
);
    import rlpq_pkg::*;

    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned XW = ((LW > POS_W) ? LW : POS_W) + 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

    t_vec            mem [MAX_LEN];
    logic [LW-1:0]   r_len;
    t_vec            r_parity, n_parity;
    t_vec            r_rd_end, r_rd_sub;
    logic            r_err, r_start_one;
    t_cnt            r_odd, r_even;
    logic            r_err_out;

    logic            load_ok;
    logic [XW-1:0]   start_x, end_x, len_x, addr_end_x, addr_sub_x;
    logic            range_bad;
    t_vec            diff;
    t_cnt            odd;

    assign load_ok  = i_cmd.load_we && (i_letter < LETTER_W'(LETTERS)) && (r_len != LEN_MAX);
    assign n_parity = r_parity ^ (t_vec'(1) << i_letter);

    assign start_x    = XW'(i_range_start);
    assign end_x      = XW'(i_range_end);
    assign len_x      = XW'(r_len);
    assign addr_end_x = end_x - XW'(1);
    assign addr_sub_x = start_x - XW'(2);
    assign range_bad  = (start_x == '0) || (start_x > end_x) || (end_x > len_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_parity <= '0;
        end else if (load_ok) begin
            r_len    <= r_len + LW'(1);
            r_parity <= n_parity;
        end
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            mem[r_len[AW-1:0]] <= n_parity;
        end
        if (i_cmd.query_cap) begin
            r_rd_end    <= mem[addr_end_x[AW-1:0]];
            r_rd_sub    <= mem[addr_sub_x[AW-1:0]];
            r_err       <= range_bad;
            r_start_one <= (start_x == XW'(1));
        end
    end

    assign diff = r_rd_end ^ (r_start_one ? '0 : r_rd_sub);
    assign odd  = popcount_vec(diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_err_out <= r_err;
            r_odd     <= r_err ? '0 : odd;
            r_even    <= r_err ? '0 : CNT_W'(LETTERS) - odd;
        end
    end

    assign o_odd_letters  = r_odd;
    assign o_even_letters = r_even;
    assign o_range_error  = r_err_out;

endmodule

@@ hw/rtl/range_letter_parity_query.sv @@
// Top level of the range letter parity query block.
// Depends on rlpq_pkg, rlpq_ctrl and rlpq_dp.
//
// Keeps a string of lowercase letters, one appended per load beat
// (opcode 0), and for every position a 26-bit prefix parity vector in a
// MAX_LEN-entry store with one write and two registered read ports. A query
// beat (opcode 1) with 1-based range_start..range_end reads the prefix
// vectors at range_end and range_start-1 (position 0 being all zeros), XORs
// them and returns the count of letters seen an odd number of times and the
// count seen an even number of times (zero included). A query with start
// below 1, start after end, or end past the loaded length returns
// range_error = 1 with both counts zero. Loads of codes 26..31, and loads
// once MAX_LEN letters are held, are dropped; loads produce no result beat.
// Sequencing: after a load beat the block is ready again the next cycle. A
// query beat moves the controller to its compute state: the store reads are
// registered at the accept edge, then XOR, popcount and the result register
// write follow in the compute state, which accepts no new beat. The result
// register decouples the output: new beats are accepted while a result
// waits; a second query only stalls in its compute cycle until the previous
// result is taken. The store has no reset and needs no clearing pass; in the
// datapath, reset clears only the length and the running parity.
module range_letter_parity_query #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic [rlpq_pkg::LETTER_W-1:0] i_letter,
    input  logic [rlpq_pkg::POS_W-1:0]    i_range_start,
    input  logic [rlpq_pkg::POS_W-1:0]    i_range_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rlpq_pkg::CNT_W-1:0]    o_odd_letters,
    output logic [rlpq_pkg::CNT_W-1:0]    o_even_letters,
    output logic                          o_range_error
);
    import rlpq_pkg::*;

    t_dp_cmd cmd;

    // sequencing and output beat valid
    rlpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (cmd)
    );

    // store, running parity, range check, popcount, result register
    rlpq_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_letter       (i_letter),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .o_odd_letters  (o_odd_letters),
        .o_even_letters (o_even_letters),
        .o_range_error  (o_range_error)
    );

endmodule

@@ dv/tb_range_letter_parity_query.sv @@
// Self-checking testbench for range_letter_parity_query.
// Depends on rlpq_pkg and the range_letter_parity_query RTL; a scoreboard class
// predicts every query result; tasks drive inputs and an always block i_ready.
`timescale 1ns / 100ps

module tb_range_letter_parity_query;
    import rlpq_pkg::*;

    localparam int unsigned MAX_LEN        = 4096;
    localparam int unsigned RANDOM_ITEMS   = 750;
    // The longest legal stretch without any beat is made of idle, stall and
    // compute cycles; stall bursts can chain, but stay far below this limit.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Cycles to keep watching after the last expected result, for strays.
    localparam int unsigned TAIL_CYCLES    = 16;

    // One predicted result beat.
    typedef struct packed {
        t_cnt odd;
        t_cnt even;
        logic err;
    } t_count_beat;

    // Predicts the block from its own copy of the letter string state and
    // holds the expected result of every accepted query, oldest first.
    class t_letter_parity_scoreboard;
        t_vec          prefix_store [MAX_LEN];
        t_vec          running_vec;
        int unsigned   loaded_len;
        t_count_beat   expected_q [$];
        int unsigned   fail_count;
        int unsigned   letters_kept;
        int unsigned   loads_dropped;
        int unsigned   queries_taken;
        int unsigned   bad_ranges;
        int unsigned   results_checked;

        function new();
            running_vec     = '0;
            loaded_len      = 0;
            fail_count      = 0;
            letters_kept    = 0;
            loads_dropped   = 0;
            queries_taken   = 0;
            bad_ranges      = 0;
            results_checked = 0;
        endfunction

        // 1-based prefix vector; position 0 is the empty prefix.
        function t_vec prefix_at(int unsigned pos);
            if (pos == 0) begin
                return '0;
            end
            return prefix_store[pos - 1];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_beat(logic op, logic [LETTER_W-1:0] letter,
                                logic [POS_W-1:0] rs, logic [POS_W-1:0] re);
            t_count_beat exp_beat;
            t_vec        diff;
            int unsigned odd;
            if (op == OP_LOAD) begin
                // codes past 'z' and loads into a full store leave no trace
                if (letter < LETTERS && loaded_len < MAX_LEN) begin
                    running_vec[letter]      = ~running_vec[letter];
                    prefix_store[loaded_len] = running_vec;
                    loaded_len++;
                    letters_kept++;
                end else begin
                    loads_dropped++;
                end
            end else begin
                queries_taken++;
                if (rs < 1 || rs > re || re > loaded_len) begin
                    exp_beat.odd  = '0;
                    exp_beat.even = '0;
                    exp_beat.err  = 1'b1;
                    bad_ranges++;
                end else begin
                    diff = prefix_at(re) ^ prefix_at(rs - 1);
                    odd  = 0;
                    for (int i = 0; i < LETTERS; i++) begin
                        odd += diff[i];
                    end
                    exp_beat.odd  = t_cnt'(odd);
                    exp_beat.even = t_cnt'(LETTERS - odd);
                    exp_beat.err  = 1'b0;
                end
                expected_q = {expected_q, exp_beat};
            end
        endfunction

        function void check_counts(t_cnt odd, t_cnt even, logic err);
            t_count_beat exp_beat;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with none expected: odd %0d even %0d err %0b",
                         $time, odd, even, err);
                fail_count++;
                return;
            end
            exp_beat = expected_q.pop_front();
            results_checked++;
            if (odd !== exp_beat.odd) begin
                $display("%0t: odd_letters expected %0d actual %0d",
                         $time, exp_beat.odd, odd);
                fail_count++;
            end
            if (even !== exp_beat.even) begin
                $display("%0t: even_letters expected %0d actual %0d",
                         $time, exp_beat.even, even);
                fail_count++;
            end
            if (err !== exp_beat.err) begin
                $display("%0t: range_error expected %0b actual %0b",
                         $time, exp_beat.err, err);
                fail_count++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_ready;
    logic                i_opcode      = OP_LOAD;
    logic [LETTER_W-1:0] i_letter      = '0;
    logic [POS_W-1:0]    i_range_start = '0;
    logic [POS_W-1:0]    i_range_end   = '0;
    logic                o_valid;
    logic                i_ready       = 1'b1;
    logic [CNT_W-1:0]    o_odd_letters;
    logic [CNT_W-1:0]    o_even_letters;
    logic                o_range_error;

    t_letter_parity_scoreboard sb;

    int unsigned tx_gap_pct    = 0;    // chance of a sender gap before a beat
    int unsigned rx_stall_pct  = 0;    // chance of a receiver stall burst
    int unsigned rx_stall_left = 0;
    int unsigned idle_cycles   = 0;
    int unsigned beats_sent    = 0;
    bit          tx_quiet      = 1'b0; // no sender gaps in the final part
    bit          rx_quiet      = 1'b0; // no receiver stalls in the final part

    range_letter_parity_query #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_letter      (i_letter),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_odd_letters (o_odd_letters),
        .o_even_letters(o_even_letters),
        .o_range_error (o_range_error)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Result side: check every accepted beat, then choose i_ready for the
    // next cycle. Stalls come in bursts of random length; the burst rate
    // switches now and then, zero included, so long stall-free runs occur.
    // Everything here is sampled at the edge, before any update from it.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_counts(o_odd_letters, o_even_letters, o_range_error);
        end
        if ($urandom_range(0, 127) == 0) begin
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 15;
                default: rx_stall_pct = 40;
            endcase
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
        end else if (!rx_quiet && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_stall_left = $urandom_range(1, 7);
        end
        i_ready <= (rx_stall_left == 0);
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_range_letter_parity_query NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Drop valid with junk on the payload, then wait out the requested idle span.
    task automatic idle_sender(input int unsigned n);
        i_valid       <= 1'b0;
        i_opcode      <= 1'($urandom_range(0, 1));
        i_letter      <= LETTER_W'($urandom_range(0, 31));
        i_range_start <= POS_W'($urandom_range(0, 8191));
        i_range_end   <= POS_W'($urandom_range(0, 8191));
        repeat (n) @(posedge i_clk);
    endtask

    // Present one beat and hold it until accepted. Valid stays high on
    // return so back-to-back beats need no extra assignment.
    task automatic send_beat(input logic op, input logic [LETTER_W-1:0] letter,
                             input logic [POS_W-1:0] rs, input logic [POS_W-1:0] re);
        if (!tx_quiet && $urandom_range(0, 99) < tx_gap_pct) begin
            idle_sender($urandom_range(1, 7));
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_letter      <= letter;
        i_range_start <= rs;
        i_range_end   <= re;
        do @(posedge i_clk); while (!o_ready);
        sb.note_beat(op, letter, rs, re);
        beats_sent++;
    endtask

    // Unused fields carry random values so every bit toggles.
    task automatic send_load(input logic [LETTER_W-1:0] letter);
        send_beat(OP_LOAD, letter, POS_W'($urandom_range(0, 8191)),
                  POS_W'($urandom_range(0, 8191)));
    endtask

    task automatic send_query(input logic [POS_W-1:0] rs, input logic [POS_W-1:0] re);
        send_beat(OP_QUERY, LETTER_W'($urandom_range(0, 31)), rs, re);
    endtask

    // Well-formed ranges sit inside the loaded string; the rest hit each
    // invalid-range rule or are plain noise over the full field width.
    task automatic send_random_query(input bit well_formed);
        int unsigned len;
        int unsigned rs;
        int unsigned re;
        len = sb.loaded_len;
        if (well_formed && len != 0) begin
            rs = $urandom_range(1, len);
            re = $urandom_range(rs, len);
            case ($urandom_range(0, 4))
                0:       rs = 1;
                1:       re = len;
                2:       re = (rs + 3 < len) ? rs + $urandom_range(0, 3) : len;
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    rs = $urandom_range(0, 8191);
                    re = $urandom_range(0, 8191);
                end
                1: begin
                    rs = 0;
                    re = $urandom_range(0, len);
                end
                2: begin
                    re = $urandom_range(0, len);
                    rs = re + 1 + $urandom_range(0, 2);
                end
                default: begin
                    rs = 1;
                    re = len + 1 + $urandom_range(0, 2);
                end
            endcase
        end
        send_query(POS_W'(rs), POS_W'(re));
    endtask

    // Hold off input until every expected result has come back; valid is
    // held low throughout the wait.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int unsigned counted;
        int unsigned next_drain;
        sb         = new();
        counted    = 0;
        next_drain = 250;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: queries on an empty string, letter extremes, codes past
        // 'z', then ranges at the edges and every invalid-range rule.
        send_query(1, 1);          // end past an empty string
        send_query(0, 0);          // start below one
        send_load(0);              // a
        send_load(25);             // z
        send_load(31);             // dropped
        send_load(26);             // dropped
        send_load(0);              // a
        send_load(1);              // b
        send_load(0);              // a -> "azaba"
        send_query(1, 5);          // whole string
        send_query(1, 1);
        send_query(5, 5);
        send_query(2, 4);
        send_query(1, 3);          // pair of a's cancels
        send_query(3, 2);          // start after end
        send_query(1, 6);          // end one past the length
        send_query(0, 5);
        send_query(8191, 8191);    // all-ones fields
        send_query(6, 8191);
        send_query(8191, 0);
        drain_results();

        // Random: mostly loads and in-range queries, with some noise.
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0:       tx_gap_pct = 0;
                    1:       tx_gap_pct = 12;
                    default: tx_gap_pct = 35;
                endcase
            end
            if (counted >= next_drain) begin
                drain_results();
                next_drain += 250;
            end
            if (sb.loaded_len < 8 || $urandom_range(0, 99) < 58) begin
                if ($urandom_range(0, 99) < 7) begin
                    send_load(LETTER_W'($urandom_range(26, 31)));
                end else begin
                    send_load(LETTER_W'($urandom_range(0, 25)));
                    counted++;
                end
            end else begin
                send_random_query($urandom_range(0, 99) < 85);
                counted++;
            end
        end

        // Final part, no idling on either side: back-to-back loads and
        // queries, with ranges at and past MAX_LEN, the largest length the store holds.
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_load(0);
        send_load(25);
        send_load(LETTER_W'($urandom_range(0, 31)));
        send_load(LETTER_W'($urandom_range(0, 25)));
        send_query(1, POS_W'(MAX_LEN));
        send_query(POS_W'(MAX_LEN), POS_W'(MAX_LEN));
        send_query(POS_W'(MAX_LEN - 1), POS_W'(MAX_LEN));
        send_query(1, POS_W'(MAX_LEN + 1));
        send_query(POS_W'(MAX_LEN + 1), POS_W'(MAX_LEN + 1));
        repeat (40) send_random_query($urandom_range(0, 99) < 80);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.fail_count++;
        end

        $display("Run covered %0d beats: %0d letters appended, %0d loads dropped, %0d queries.",
                 beats_sent, sb.letters_kept, sb.loads_dropped, sb.queries_taken);
        $display("String grew to %0d positions; %0d results compared, %0d invalid ranges.",
                 sb.loaded_len, sb.results_checked, sb.bad_ranges);
        if (sb.fail_count == 0) begin
            $display("tb_range_letter_parity_query OK");
        end else begin
            $display("tb_range_letter_parity_query NOT OK");
        end
        $finish;
    end

endmodule
